// ----- rtl/srim_pkg.sv -----
// Shared types and constants for the S-record image checker.
// No dependencies; imported by every module of the block.
package srim_pkg;

    localparam int MAX_DATA_BYTES = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [4:0] WBL_RESET = 5'd13;
    localparam logic [4:0] WBL_MAX   = 5'd24;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_S   = 8'h53;

    localparam logic [3:0] RT_NONE = 4'd10;
    localparam logic [7:0] CKSUM_GOOD = 8'hFF;

    typedef enum logic [2:0] {
        ST_DATA_OK    = 3'd0,
        ST_HEADER     = 3'd1,
        ST_END        = 3'd2,
        ST_FORMAT_ERR = 3'd3,
        ST_CKSUM_ERR  = 3'd4,
        ST_SKIPPED    = 3'd5
    } status_t;

    typedef struct packed {
        logic       eol;
        logic       is_s;
        logic       hex_ok;
        logic [3:0] nib;
        logic [3:0] rtype;
    } tok_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] low;
        logic [32:0] high;
        logic [32:0] span;
        logic [15:0] dsum;
        logic [31:0] dcount;
        logic [32:0] bm1;
    } res_t;

endpackage

// ----- rtl/srecord_image_checker.sv -----
// S-record image checker top level: front end, token queue, record engine.
// Throughput: one character per cycle while the token queue is not full; whitespace is taken and dropped.
// A carriage return's result passes the queue, snapshot, span, rounding and
// gap/sum output registers in that order.
// Reset: rst_n clears line and image state; write_block_log2 resets to 13.
module srecord_image_checker
    import srim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] low_address,
    output logic [32:0] end_address,
    output logic [32:0] image_size,
    output logic [15:0] image_sum
);

    logic push, full, pop, empty;
    tok_t wr_tok, rd_tok;
    res_t out_res;

    srim_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .fifo_full (full),
        .push      (push),
        .tok       (wr_tok)
    );

    srim_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_tok (wr_tok),
        .full   (full),
        .pop    (pop),
        .rd_tok (rd_tok),
        .empty  (empty)
    );

    srim_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .empty       (empty),
        .tok         (rd_tok),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (out_res)
    );

    assign status      = out_res.status;
    assign low_address = out_res.low;
    assign end_address = out_res.high;
    assign image_size  = out_res.span;
    assign image_sum   = out_res.dsum;

endmodule

// ----- rtl/srim_front.sv -----
// Front end: accepts characters, drops whitespace and classifies the rest.
// Depends on srim_pkg; feeds srim_fifo.
module srim_front
    import srim_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       fifo_full,
    output logic       push,
    output tok_t       tok
);

    logic is_ws;

    always_comb
    begin
        is_ws      = (ch == CH_LF) || (ch == CH_TAB) || (ch == CH_SP);
        tok.eol    = (ch == CH_CR);
        tok.is_s   = (ch == CH_S);
        tok.hex_ok = 1'b0;
        tok.nib    = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            tok.hex_ok = 1'b1;
            tok.nib    = ch[3:0];
        end
        else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
        begin
            tok.hex_ok = 1'b1;
            tok.nib    = ch[3:0] + 4'd9;
        end
        tok.rtype = (ch >= 8'h30 && ch <= 8'h39) ? ch[3:0] : RT_NONE;
    end

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full && !is_ws;

endmodule

// ----- rtl/srim_fifo.sv -----
// Short token queue between the front end and the record engine.
// Depends on srim_pkg.
module srim_fifo
    import srim_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tok_t wr_tok,
    output logic full,
    input  logic pop,
    output tok_t rd_tok,
    output logic empty
);

    tok_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_tok  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

// ----- rtl/srim_back.sv -----
// Record engine: decodes records, keeps image accumulators, builds results.
// Depends on srim_pkg; drains srim_fifo and drives the output register.
module srim_back
    import srim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        empty,
    input  tok_t        tok,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_res
);

    logic [4:0]  wbl_reg;
    logic [6:0]  pos_reg, pos_next;
    logic [3:0]  rtype_reg, rtype_next;
    logic [7:0]  bc_reg, bc_next;
    logic [32:0] addr_reg, addr_next;
    logic [7:0]  cks_reg, cks_next;
    logic [3:0]  hn_reg, hn_next;
    logic        bad_reg, bad_next;
    logic        abort_reg, abort_next;
    logic [31:0] min_reg, min_next;
    logic [32:0] max_reg, max_next;
    logic [15:0] sum_reg, sum_next;
    logic [31:0] count_reg, count_next;

    logic        s1_valid_reg, s1_valid_next;
    logic        s2_valid_reg, s2_valid_next;
    logic        s3_valid_reg, s3_valid_next;
    logic        out_valid_reg, out_valid_next;
    res_t        s1_reg, s1_next;
    res_t        s2_reg, s2_next;
    res_t        s3_reg, s3_next;
    res_t        out_reg, out_next;

    logic        en;
    logic        s1_load;
    res_t        s1_res;
    logic        bad_now;
    logic        rt_data;
    logic [9:0]  lim;
    logic [6:0]  pos_m2;
    logic [5:0]  idx;
    logic [2:0]  alen;
    logic [7:0]  b;
    logic [8:0]  cnt_lo, cnt_hi;
    logic [32:0] addr_shift;
    logic [4:0]  lg;
    logic [32:0] gap;
    logic [15:0] g16;

    assign en = !out_valid_reg || out_ready;

    always_comb
    begin
        pos_next   = pos_reg;
        rtype_next = rtype_reg;
        bc_next    = bc_reg;
        addr_next  = addr_reg;
        cks_next   = cks_reg;
        hn_next    = hn_reg;
        bad_next   = bad_reg;
        abort_next = abort_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        pop        = 1'b0;
        s1_load    = 1'b0;
        s1_res     = '0;
        bad_now    = bad_reg;
        rt_data    = (rtype_reg >= 4'd1) && (rtype_reg <= 4'd3);
        lim        = {1'b0, bc_reg, 1'b0} + 10'd4;
        pos_m2     = pos_reg - 7'd2;
        idx        = pos_m2[6:1];
        alen       = rtype_reg[2:0] + 3'd1;
        b          = {hn_reg, tok.nib};
        cnt_lo     = {6'd0, alen} + 9'd1;
        cnt_hi     = cnt_lo + 9'(MAX_DATA_BYTES);
        addr_shift = {addr_reg[24:0], b};
        lg         = (wbl_reg > WBL_MAX) ? WBL_MAX : wbl_reg;

        if (!empty && tok.eol && en)
        begin
            pop     = 1'b1;
            s1_load = 1'b1;
            if (pos_reg >= 7'd2 && rtype_reg >= 4'd7 && rtype_reg <= 4'd9)
            begin
                s1_res.status = ST_END;
                s1_res.low    = min_reg;
                s1_res.high   = max_reg;
                s1_res.dsum   = sum_reg;
                s1_res.dcount = count_reg;
                s1_res.bm1    = (33'd1 << lg) - 33'd1;
                abort_next    = 1'b0;
                min_next      = '1;
                max_next      = '0;
                sum_next      = '0;
                count_next    = '0;
            end
            else if (abort_reg)
            begin
                s1_res.status = ST_SKIPPED;
            end
            else if (pos_reg >= 7'd2 && rtype_reg == 4'd0)
            begin
                s1_res.status = ST_HEADER;
            end
            else if (pos_reg >= 7'd2 && rt_data)
            begin
                if (bad_reg || {3'd0, pos_reg} < lim)
                begin
                    s1_res.status = ST_FORMAT_ERR;
                    abort_next    = 1'b1;
                end
                else
                begin
                    if (addr_reg > max_reg)
                    begin
                        max_next = addr_reg;
                    end
                    if (cks_reg != CKSUM_GOOD)
                    begin
                        s1_res.status = ST_CKSUM_ERR;
                        abort_next    = 1'b1;
                    end
                    else
                    begin
                        s1_res.status = ST_DATA_OK;
                    end
                end
            end
            else
            begin
                s1_res.status = ST_FORMAT_ERR;
                abort_next    = 1'b1;
            end
            pos_next   = '0;
            rtype_next = '0;
            bc_next    = '0;
            addr_next  = '0;
            cks_next   = '0;
            hn_next    = '0;
            bad_next   = 1'b0;
        end
        else if (!empty && !tok.eol)
        begin
            pop = 1'b1;
            if (pos_reg == 7'd0)
            begin
                if (!tok.is_s)
                begin
                    bad_next = 1'b1;
                end
            end
            else if (pos_reg == 7'd1)
            begin
                rtype_next = tok.rtype;
            end
            else if (rt_data && (pos_reg < 7'd4 || {3'd0, pos_reg} < lim))
            begin
                bad_now  = bad_reg || !tok.hex_ok;
                bad_next = bad_now;
                if (!pos_reg[0])
                begin
                    hn_next = tok.nib;
                end
                else if (idx == 6'd0)
                begin
                    bc_next  = b;
                    cks_next = b;
                    if ({1'b0, b} < cnt_lo || {1'b0, b} > cnt_hi)
                    begin
                        bad_next = 1'b1;
                    end
                end
                else if ({3'd0, idx} <= {6'd0, alen})
                begin
                    addr_next = addr_shift;
                    cks_next  = cks_reg + b;
                    if (idx == {3'd0, alen} && !bad_now && !abort_reg
                        && addr_shift[31:0] < min_reg)
                    begin
                        min_next = addr_shift[31:0];
                    end
                end
                else if ({2'd0, idx} < bc_reg)
                begin
                    cks_next  = cks_reg + b;
                    addr_next = addr_reg + 33'd1;
                    if (!bad_now && !abort_reg)
                    begin
                        sum_next   = sum_reg + {8'd0, b};
                        count_next = count_reg + 32'd1;
                    end
                end
                else if ({2'd0, idx} == bc_reg)
                begin
                    cks_next = cks_reg + b;
                end
            end
            if (pos_reg != 7'd127)
            begin
                pos_next = pos_reg + 7'd1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        s3_valid_next  = s3_valid_reg;
        out_valid_next = out_valid_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        s3_next        = s3_reg;
        out_next       = out_reg;
        gap            = '0;
        g16            = '0;
        if (en)
        begin
            s1_valid_next  = s1_load;
            s2_valid_next  = s1_valid_reg;
            s3_valid_next  = s2_valid_reg;
            out_valid_next = s3_valid_reg;
            s1_next        = s1_res;

            s2_next      = s1_reg;
            s2_next.span = (s1_reg.high >= {1'b0, s1_reg.low})
                         ? s1_reg.high - {1'b0, s1_reg.low} : 33'd0;

            s3_next      = s2_reg;
            s3_next.span = (s2_reg.span + s2_reg.bm1) & ~s2_reg.bm1;

            gap = (s3_reg.span > {1'b0, s3_reg.dcount})
                ? s3_reg.span - {1'b0, s3_reg.dcount} : 33'd0;
            g16 = gap[15:0];
            out_next      = s3_reg;
            out_next.dsum = s3_reg.dsum + {g16[7:0], 8'h00} - g16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wbl_reg       <= WBL_RESET;
            pos_reg       <= '0;
            rtype_reg     <= '0;
            bc_reg        <= '0;
            addr_reg      <= '0;
            cks_reg       <= '0;
            hn_reg        <= '0;
            bad_reg       <= 1'b0;
            abort_reg     <= 1'b0;
            min_reg       <= '1;
            max_reg       <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wbl_reg <= cfg_wr_data;
            end
            pos_reg       <= pos_next;
            rtype_reg     <= rtype_next;
            bc_reg        <= bc_next;
            addr_reg      <= addr_next;
            cks_reg       <= cks_next;
            hn_reg        <= hn_next;
            bad_reg       <= bad_next;
            abort_reg     <= abort_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

// ----- rtl/srim_checker.sv -----
// Port-level assertions for the S-record image checker, bound to the top.
// Depends on srim_pkg and srecord_image_checker.
module srim_checker
    import srim_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] low_address,
    input logic [32:0] end_address,
    input logic [32:0] image_size,
    input logic [15:0] image_sum
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(image_sum)
            && $stable(image_size))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_SKIPPED)
        else $error("status code out of range");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_END |-> low_address == 32'd0
            && end_address == 33'd0 && image_size == 33'd0 && image_sum == 16'd0)
        else $error("summary fields set on non-end result");

    a_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_END && end_address < {1'b0, low_address}
            |-> image_size == 33'd0)
        else $error("empty image with nonzero span");

endmodule

bind srecord_image_checker srim_checker u_srim_checker (.*);

// ----- dv/srecord_image_checker_tb.sv -----
`timescale 1ns / 1ps
// Testbench for srecord_image_checker: S-record text streams in, per-record reports out.
// Depends on srim_pkg and the RTL only; a scoreboard class predicts every report.
module srecord_image_checker_tb;
    import srim_pkg::*;

    localparam int LIMIT        = 600000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_CHARS  = 200;
    localparam int RAND_CHARS   = 600;

    typedef struct {
        status_t     st;
        logic [31:0] low;
        logic [32:0] end_addr;
        logic [32:0] size;
        logic [15:0] sum;
    } image_result_t;

    typedef enum int {
        FL_NONE,
        FL_LOWER,
        FL_TRAIL,
        FL_CKSUM,
        FL_BADHEX,
        FL_SHORT,
        FL_COUNT_LOW,
        FL_COUNT_HIGH,
        FL_NOT_S,
        FL_TYPE
    } flaw_t;

    class image_scoreboard;
        logic [4:0]    block_log2;
        logic [6:0]    pos;
        logic [3:0]    rtype;
        logic [7:0]    count;
        logic [32:0]   rec_addr;
        logic [7:0]    csum;
        logic [3:0]    hi_nib;
        bit            line_bad;
        bit            aborted;
        logic [31:0]   min_addr;
        logic [32:0]   max_addr;
        logic [31:0]   byte_sum;
        logic [31:0]   data_bytes;
        image_result_t pending_reports[$];
        int            errors;
        int            results_seen;

        function new();
            block_log2   = WBL_RESET;
            errors       = 0;
            results_seen = 0;
            clear_line();
            clear_image();
        endfunction

        function void clear_line();
            pos      = '0;
            rtype    = '0;
            count    = '0;
            rec_addr = '0;
            csum     = '0;
            hi_nib   = '0;
            line_bad = 1'b0;
        endfunction

        function void clear_image();
            aborted    = 1'b0;
            min_addr   = '1;
            max_addr   = '0;
            byte_sum   = '0;
            data_bytes = '0;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "A" && c <= "F") return c - "A" + 10;
            if (c >= "a" && c <= "f") return c - "a" + 10;
            return -1;
        endfunction

        function void take_byte(logic [7:0] b);
            int idx;
            int alen;
            idx  = (int'(pos) - 2) >>> 1;
            alen = int'(rtype) + 1;
            if (idx == 0)
            begin
                count = b;
                csum  = b;
                if (int'(b) < alen + 1 || int'(b) - alen - 1 > MAX_DATA_BYTES)
                    line_bad = 1'b1;
            end
            else if (idx <= alen)
            begin
                rec_addr = {rec_addr[24:0], b};
                csum     = csum + b;
                if (idx == alen && !line_bad && !aborted && rec_addr[31:0] < min_addr)
                    min_addr = rec_addr[31:0];
            end
            else if (idx < int'(count))
            begin
                csum = csum + b;
                if (!line_bad && !aborted)
                begin
                    byte_sum   = byte_sum + {24'd0, b};
                    data_bytes = data_bytes + 32'd1;
                end
                rec_addr = rec_addr + 33'd1;
            end
            else if (idx == int'(count))
            begin
                csum = csum + b;
            end
        endfunction

        function void close_record();
            image_result_t   r;
            int unsigned     lg;
            longint unsigned blk;
            longint unsigned span;
            longint unsigned gap;
            longint unsigned total;
            bit              has_type;
            has_type   = pos >= 2;
            r.st       = ST_DATA_OK;
            r.low      = '0;
            r.end_addr = '0;
            r.size     = '0;
            r.sum      = '0;
            if (has_type && (rtype == 7 || rtype == 8 || rtype == 9))
            begin
                lg   = (block_log2 > WBL_MAX) ? WBL_MAX : block_log2;
                blk  = 64'd1 << lg;
                span = 0;
                if (max_addr >= {1'b0, min_addr})
                    span = max_addr - min_addr;
                span  = (span + blk - 1) & ~(blk - 1);
                gap   = (span > data_bytes) ? span - data_bytes : 0;
                total = byte_sum + 64'd255 * gap;
                r.st       = ST_END;
                r.low      = min_addr;
                r.end_addr = max_addr;
                r.size     = span[32:0];
                r.sum      = total[15:0];
                clear_image();
            end
            else if (aborted)
            begin
                r.st = ST_SKIPPED;
            end
            else if (has_type && rtype == 0)
            begin
                r.st = ST_HEADER;
            end
            else if (has_type && rtype >= 1 && rtype <= 3)
            begin
                if (line_bad || int'(pos) < 2 * int'(count) + 4)
                begin
                    r.st    = ST_FORMAT_ERR;
                    aborted = 1'b1;
                end
                else
                begin
                    if (rec_addr > max_addr)
                        max_addr = rec_addr;
                    if (csum != CKSUM_GOOD)
                    begin
                        r.st    = ST_CKSUM_ERR;
                        aborted = 1'b1;
                    end
                end
            end
            else
            begin
                r.st    = ST_FORMAT_ERR;
                aborted = 1'b1;
            end
            pending_reports.push_back(r);
            clear_line();
        endfunction

        function void absorb_char(logic [7:0] c);
            int v;
            int p;
            p = pos;
            if (c == CH_LF || c == CH_TAB || c == CH_SP)
                return;
            if (c == CH_CR)
            begin
                close_record();
                return;
            end
            if (p == 0)
            begin
                if (c != CH_S)
                    line_bad = 1'b1;
            end
            else if (p == 1)
            begin
                rtype = (c >= "0" && c <= "9") ? c[3:0] : RT_NONE;
            end
            else if (rtype >= 1 && rtype <= 3 && (p < 4 || p < 2 * int'(count) + 4))
            begin
                v = hex_digit(c);
                if (v < 0)
                begin
                    line_bad = 1'b1;
                    v = 0;
                end
                if (p % 2 == 0)
                    hi_nib = v[3:0];
                else
                    take_byte({hi_nib, v[3:0]});
            end
            if (pos < 7'd127)
                pos = pos + 7'd1;
        endfunction

        function void compare_result(logic [2:0] st, logic [31:0] low, logic [32:0] ea,
                                     logic [32:0] sz, logic [15:0] sm);
            image_result_t e;
            results_seen++;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected report: status %0d with none pending", st);
                errors++;
                return;
            end
            e = pending_reports.pop_front();
            if (st !== e.st)
            begin
                $error("status: expected %0d, got %0d", e.st, st);
                errors++;
            end
            if (low !== e.low)
            begin
                $error("low_address: expected %0h, got %0h", e.low, low);
                errors++;
            end
            if (ea !== e.end_addr)
            begin
                $error("end_address: expected %0h, got %0h", e.end_addr, ea);
                errors++;
            end
            if (sz !== e.size)
            begin
                $error("image_size: expected %0h, got %0h", e.size, sz);
                errors++;
            end
            if (sm !== e.sum)
            begin
                $error("image_sum: expected %0h, got %0h", e.sum, sm);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] low_address;
    logic [32:0] end_address;
    logic [32:0] image_size;
    logic [15:0] image_sum;

    image_scoreboard sb;
    logic [7:0]      line_buf[$];
    logic [31:0]     image_base;
    int              image_rt;
    int              text_chars;
    int              cycles = 0;
    bit              tx_quiet;
    bit              rx_quiet;

    srecord_image_checker u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .low_address (low_address),
        .end_address (end_address),
        .image_size  (image_size),
        .image_sum   (image_sum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && in_ready)
            sb.absorb_char(ch);
        if (rst_n && out_valid && out_ready)
            sb.compare_result(status, low_address, end_address, image_size, image_sum);
    end

    initial
    begin
        wait (cycles >= LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        rx_quiet  = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_char(logic [7:0] c);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (c != CH_LF && c != CH_TAB && c != CH_SP)
            text_chars++;
    endtask

    task automatic send_line();
        logic [7:0] blanks[3];
        blanks = '{CH_LF, CH_TAB, CH_SP};
        if ($urandom_range(0, 7) == 0)
            tx_quiet = !tx_quiet;
        foreach (line_buf[k])
        begin
            if ($urandom_range(0, 24) == 0)
                send_char(blanks[$urandom_range(0, 2)]);
            send_char(line_buf[k]);
        end
        send_char(CH_CR);
    endtask

    // hold off input until every report is out and the pipeline is quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_block_log2(logic [4:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.block_log2 = v;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LF || c == CH_TAB || c == CH_SP || c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do
            c = plain_char();
        while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
        return c;
    endfunction

    function automatic logic [7:0] hex_ch(logic [3:0] n, bit lower);
        if (n < 10)
            return 8'("0" + n);
        return 8'((lower ? "a" : "A") + n - 10);
    endfunction

    function automatic void truncate_line(int keep);
        while (line_buf.size() > keep)
            void'(line_buf.pop_back());
    endfunction

    function automatic void build_record(int rt, logic [31:0] addr, int nbytes, int fill,
                                         flaw_t flaw);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] c;
        int         alen;
        int         cnt;
        bit         lower;
        lower = (flaw == FL_LOWER);
        alen  = (rt >= 7) ? 11 - rt : (rt == 0) ? 2 : rt + 1;
        body.push_back(8'(alen + nbytes + 1));
        for (int k = alen - 1; k >= 0; k--)
            body.push_back(addr[8*k +: 8]);
        for (int k = 0; k < nbytes; k++)
            body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        sum = '0;
        foreach (body[k])
            sum = sum + body[k];
        body.push_back(~sum);
        case (flaw)
            FL_CKSUM:
                body[body.size() - 1] ^= 8'($urandom_range(1, 255));
            FL_COUNT_LOW:
                body[0] = 8'($urandom_range(0, alen));
            FL_COUNT_HIGH:
            begin
                cnt = $urandom_range(alen + MAX_DATA_BYTES + 2, 255);
                body[0] = 8'(cnt);
                if (cnt <= 61)
                    while (body.size() < cnt + 1)
                        body.push_back(8'($urandom));
            end
            default: ;
        endcase
        line_buf.delete();
        line_buf.push_back(flaw == FL_NOT_S ? ((plain_char() == CH_S) ? "T" : plain_char())
                                            : CH_S);
        if (flaw == FL_TYPE)
        begin
            if ($urandom_range(0, 1) == 0)
                c = 8'("4" + $urandom_range(0, 2));
            else
                do
                    c = plain_char();
                while (c inside {"0", "1", "2", "3", "7", "8", "9"});
            line_buf.push_back(c);
        end
        else
        begin
            line_buf.push_back(8'("0" + rt));
        end
        foreach (body[k])
        begin
            line_buf.push_back(hex_ch(body[k][7:4], lower));
            line_buf.push_back(hex_ch(body[k][3:0], lower));
        end
        case (flaw)
            FL_BADHEX:
                line_buf[$urandom_range(2, line_buf.size() - 1)] = non_hex_char();
            FL_SHORT:
                truncate_line($urandom_range(0, line_buf.size() - 1));
            FL_TRAIL:
                repeat ($urandom_range(1, 70)) line_buf.push_back(plain_char());
            default: ;
        endcase
    endfunction

    task automatic send_record(int rt, logic [31:0] addr, int nbytes, int fill, flaw_t flaw);
        build_record(rt, addr, nbytes, fill, flaw);
        send_line();
    endtask

    function automatic logic [31:0] pick_address(int rt);
        logic [31:0] a;
        int          r;
        r = $urandom_range(0, 15);
        if (r == 0)
            a = '1;
        else if (r == 1)
            a = '0;
        else
            a = image_base + $urandom_range(0, 32'h3000);
        if (rt == 1)
            a[31:16] = '0;
        else if (rt == 2)
            a[31:24] = '0;
        return a;
    endfunction

    task automatic end_image();
        int rt;
        rt = $urandom_range(7, 9);
        build_record(rt, $urandom, 0, -1, FL_NONE);
        if ($urandom_range(0, 4) == 0)
            truncate_line(2);
        send_line();
        image_base = $urandom & 32'hFFFF_F000;
        image_rt   = $urandom_range(1, 3);
    endtask

    task automatic random_line();
        int    pick;
        int    rt;
        int    n;
        int    roll;
        flaw_t fl;
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        if (roll < 12)
            fl = flaw_t'($urandom_range(FL_CKSUM, FL_TYPE));
        else if (roll < 20)
            fl = FL_LOWER;
        else if (roll < 25)
            fl = FL_TRAIL;
        else
            fl = FL_NONE;
        if (pick < 6)
        begin
            send_record(0, $urandom, $urandom_range(0, 20), -1, fl);
        end
        else if (pick < 15)
        begin
            end_image();
        end
        else if (pick < 20)
        begin
            line_buf.delete();
            repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom));
            send_line();
        end
        else
        begin
            rt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : image_rt;
            n  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_DATA_BYTES)
                                             : $urandom_range(0, 8);
            send_record(rt, pick_address(rt), n, -1, fl);
        end
    endtask

    initial
    begin
        int         phase;
        int         start_chars;
        int         rand_chars;
        int         keep_lens[4];
        logic [4:0] wbl;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        ch          = '0;
        text_chars  = 0;
        tx_quiet    = 1'b0;
        image_base  = 32'h0001_0000;
        image_rt    = 1;
        keep_lens   = '{0, 1, 2, 7};
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_block_log2(5'd0);
        send_record(0, 32'h0, 5, -1, FL_NONE);
        // overlapping records: more data bytes than span
        send_record(1, 32'h1000, 8, -1, FL_NONE);
        send_record(1, 32'h1000, 8, -1, FL_NONE);
        send_record(9, 32'h0, 0, -1, FL_NONE);
        send_record(1, 32'h0, MAX_DATA_BYTES, 8'h00, FL_NONE);
        send_record(1, 32'hFFFF, MAX_DATA_BYTES, 8'hFF, FL_LOWER);
        send_record(8, 32'h0, 0, -1, FL_NONE);
        send_record(2, 32'h00FF_FFFF, 1, -1, FL_NONE);
        send_record(3, 32'hFFFF_FFE0, MAX_DATA_BYTES, -1, FL_NONE);
        send_record(3, 32'hFFFF_FFFF, MAX_DATA_BYTES, -1, FL_NONE);
        send_record(3, 32'h0, 0, -1, FL_NONE);
        send_record(7, 32'h0, 0, -1, FL_NONE);
        send_record(9, 32'h0, 0, -1, FL_NONE);
        for (int f = FL_CKSUM; f <= FL_TYPE; f++)
        begin
            send_record(1, 32'h2000, 4, -1, flaw_t'(f));
            send_record(9, 32'h0, 0, -1, FL_NONE);
        end
        foreach (keep_lens[k])
        begin
            build_record(1, 32'h1234, 4, -1, FL_NONE);
            truncate_line(keep_lens[k]);
            send_line();
            send_record(9, 32'h0, 0, -1, FL_NONE);
        end
        // error sticks until the end record
        send_record(2, 32'h5000, 3, -1, FL_CKSUM);
        send_record(2, 32'h5003, 3, -1, FL_NONE);
        send_record(0, 32'h0, 2, -1, FL_NONE);
        send_record(8, 32'h0, 0, -1, FL_NONE);
        build_record(3, 32'h4000, MAX_DATA_BYTES, -1, FL_NONE);
        repeat (60) line_buf.push_back(plain_char());
        send_line();
        send_record(7, 32'h0, 0, -1, FL_NONE);

        phase      = 0;
        rand_chars = text_chars;
        while (text_chars - rand_chars < RAND_CHARS)
        begin
            drain();
            case (phase)
                0:       wbl = WBL_RESET;
                1:       wbl = WBL_MAX;
                2:       wbl = 5'd31;
                default: wbl = 5'($urandom_range(0, 31));
            endcase
            write_block_log2(wbl);
            start_chars = text_chars;
            while (text_chars - start_chars < PHASE_CHARS)
                random_line();
            end_image();
            phase++;
        end

        drain();
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
